// ===== sv/pdf_pkg.sv =====
// ---------------------------------------------------------------------------
// Peer delay filter package
// Shared types, constants and seconds/nanoseconds helpers.
// ---------------------------------------------------------------------------
package pdf_pkg;

	localparam int SEC_W   = 32;
	localparam int WNS_W   = 34;
	localparam int NS_W    = 31;
	localparam int TSNS_W  = 30;
	localparam int STIFF_W = 5;
	localparam int STEP_W  = 31;
	localparam int DIV_W   = 32;
	localparam int FIFO_DEPTH = 2;

	localparam logic [STIFF_W-1:0] STIFF_RESET = 5'd6;
	localparam logic [STIFF_W-1:0] STIFF_MAX   = 5'd30;

	localparam logic signed [WNS_W-1:0] NS_ONE = 34'sd1000000000;
	localparam logic signed [WNS_W-1:0] NS_TWO = 34'sd2000000000;

	// Pair with headroom on the nanoseconds for unnormalised sums.
	typedef struct packed {
		logic [SEC_W-1:0] sec;
		logic [WNS_W-1:0] ns;
	} pdf_wide_t;

	// Normalised pair as handed from front to back.
	typedef struct packed {
		logic [SEC_W-1:0] sec;
		logic [NS_W-1:0]  ns;
	} pdf_pair_t;

	typedef enum logic [1:0] {
		FS_IDLE,
		FS_RAW,
		FS_NORM,
		FS_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		ST_DIFF_A,
		ST_DIFF_B,
		ST_SUM,
		ST_CORR,
		ST_HALF
	} front_step_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SEARCH,
		BK_STEP,
		BK_DIV,
		BK_WAIT,
		BK_SUM,
		BK_OUT
	} back_state_t;

	// Moves whole seconds across and makes both parts agree in sign.
	function automatic pdf_wide_t pair_norm(pdf_wide_t t);
		logic signed [SEC_W-1:0] sec1;
		logic signed [WNS_W-1:0] ns1;
		pdf_wide_t r;
		sec1 = $signed(t.sec);
		ns1  = $signed(t.ns);
		if (ns1 >= NS_TWO) begin
			sec1 = sec1 + 32'sd2;
			ns1  = ns1 - NS_TWO;
		end else if (ns1 >= NS_ONE) begin
			sec1 = sec1 + 32'sd1;
			ns1  = ns1 - NS_ONE;
		end else if (ns1 <= -NS_TWO) begin
			sec1 = sec1 - 32'sd2;
			ns1  = ns1 + NS_TWO;
		end else if (ns1 <= -NS_ONE) begin
			sec1 = sec1 - 32'sd1;
			ns1  = ns1 + NS_ONE;
		end
		if (sec1 > 32'sd0 && ns1 < 34'sd0) begin
			sec1 = sec1 - 32'sd1;
			ns1  = ns1 + NS_ONE;
		end else if (sec1 < 32'sd0 && ns1 > 34'sd0) begin
			sec1 = sec1 + 32'sd1;
			ns1  = ns1 - NS_ONE;
		end
		r.sec = sec1;
		r.ns  = ns1;
		return r;
	endfunction

	// Halves a pair with truncation towards zero, before normalisation.
	function automatic pdf_wide_t pair_half(pdf_wide_t a);
		logic signed [WNS_W-1:0] nsr;
		logic signed [SEC_W-1:0] sh;
		pdf_wide_t r;
		if (a.sec[0])
			nsr = $signed(a.ns) + (a.sec[SEC_W-1] ? -NS_ONE : NS_ONE);
		else
			nsr = $signed(a.ns);
		sh = ($signed(a.sec) >>> 1)
			+ $signed({{(SEC_W-1){1'b0}}, a.sec[SEC_W-1] & a.sec[0]});
		r.sec = sh;
		r.ns  = (nsr >>> 1) + $signed({{(WNS_W-1){1'b0}}, nsr[WNS_W-1] & nsr[0]});
		return r;
	endfunction

endpackage

// ===== sv/pdf_fifo.sv =====
// ---------------------------------------------------------------------------
// Peer delay filter hand-over queue
// Short queue of halved delays between the front and the back.
// ---------------------------------------------------------------------------
module pdf_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  pdf_pkg::pdf_pair_t wdata,
	input  logic              pop,
	output logic              empty,
	output pdf_pkg::pdf_pair_t rdata
);

	localparam int PTR_W = $clog2(pdf_pkg::FIFO_DEPTH);

	pdf_pkg::pdf_pair_t mem_q [pdf_pkg::FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == (PTR_W+1)'(pdf_pkg::FIFO_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(pdf_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(pdf_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== sv/pdf_front.sv =====
// ---------------------------------------------------------------------------
// Peer delay filter front end
// Takes exchanges, drops held ones and forms the halved delay pair.
// ---------------------------------------------------------------------------
module pdf_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic                two_step,
	input  logic                leap_hold,
	input  logic [31:0]         req_send_sec,
	input  logic [29:0]         req_send_ns,
	input  logic [31:0]         req_recv_sec,
	input  logic [29:0]         req_recv_ns,
	input  logic [31:0]         resp_send_sec,
	input  logic [29:0]         resp_send_ns,
	input  logic [31:0]         resp_recv_sec,
	input  logic [29:0]         resp_recv_ns,
	input  logic [31:0]         corr_sec,
	input  logic [30:0]         corr_ns,
	output logic                q_push,
	input  logic                q_full,
	output pdf_pkg::pdf_pair_t  q_data
);

	pdf_pkg::front_state_t state_q, state_d;
	pdf_pkg::front_step_t  step_q;
	logic                  two_q;
	pdf_pkg::pdf_wide_t    t1_q, t2_q, t3_q, t4_q, corr_q;
	pdf_pkg::pdf_wide_t    acc_q, oth_q, raw_q, raw_d, nrm;
	logic                  accept;

	assign accept = push && !full;

	// The raw operation of the current step, normalised in the next cycle.
	always_comb begin
		case (step_q)
			pdf_pkg::ST_DIFF_A: begin
				raw_d.sec = t4_q.sec - (two_q ? t3_q.sec : t1_q.sec);
				raw_d.ns  = t4_q.ns - (two_q ? t3_q.ns : t1_q.ns);
			end
			pdf_pkg::ST_DIFF_B: begin
				raw_d.sec = t2_q.sec - t1_q.sec;
				raw_d.ns  = t2_q.ns - t1_q.ns;
			end
			pdf_pkg::ST_SUM: begin
				raw_d.sec = acc_q.sec + oth_q.sec;
				raw_d.ns  = acc_q.ns + oth_q.ns;
			end
			pdf_pkg::ST_CORR: begin
				raw_d.sec = acc_q.sec - corr_q.sec;
				raw_d.ns  = acc_q.ns - corr_q.ns;
			end
			pdf_pkg::ST_HALF: raw_d = pdf_pkg::pair_half(acc_q);
			default:          raw_d = acc_q;
		endcase
	end

	assign nrm = pdf_pkg::pair_norm(raw_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			pdf_pkg::FS_IDLE: if (accept && !leap_hold) state_d = pdf_pkg::FS_RAW;
			pdf_pkg::FS_RAW:  state_d = pdf_pkg::FS_NORM;
			pdf_pkg::FS_NORM: state_d = (step_q == pdf_pkg::ST_HALF) ? pdf_pkg::FS_PUSH
				: pdf_pkg::FS_RAW;
			pdf_pkg::FS_PUSH: if (!q_full) state_d = pdf_pkg::FS_IDLE;
			default:          state_d = pdf_pkg::FS_IDLE;
		endcase
	end

	always_comb begin
		full       = (state_q != pdf_pkg::FS_IDLE);
		q_push     = (state_q == pdf_pkg::FS_PUSH);
		q_data.sec = acc_q.sec;
		q_data.ns  = acc_q.ns[pdf_pkg::NS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pdf_pkg::FS_IDLE;
			step_q  <= pdf_pkg::ST_DIFF_A;
		end else begin
			state_q <= state_d;
			if (state_q == pdf_pkg::FS_IDLE) begin
				step_q <= pdf_pkg::ST_DIFF_A;
			end else if (state_q == pdf_pkg::FS_NORM) begin
				case (step_q)
					pdf_pkg::ST_DIFF_A: step_q <= two_q ? pdf_pkg::ST_DIFF_B : pdf_pkg::ST_CORR;
					pdf_pkg::ST_DIFF_B: step_q <= pdf_pkg::ST_SUM;
					pdf_pkg::ST_SUM:    step_q <= pdf_pkg::ST_CORR;
					pdf_pkg::ST_CORR:   step_q <= pdf_pkg::ST_HALF;
					default:            step_q <= step_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == pdf_pkg::FS_IDLE && accept) begin
			two_q      <= two_step;
			t1_q.sec   <= req_send_sec;
			t1_q.ns    <= {4'd0, req_send_ns};
			t2_q.sec   <= req_recv_sec;
			t2_q.ns    <= {4'd0, req_recv_ns};
			t3_q.sec   <= resp_send_sec;
			t3_q.ns    <= {4'd0, resp_send_ns};
			t4_q.sec   <= resp_recv_sec;
			t4_q.ns    <= {4'd0, resp_recv_ns};
			corr_q.sec <= corr_sec;
			corr_q.ns  <= {{3{corr_ns[30]}}, corr_ns};
		end
		if (state_q == pdf_pkg::FS_RAW)
			raw_q <= raw_d;
		if (state_q == pdf_pkg::FS_NORM) begin
			if (step_q == pdf_pkg::ST_DIFF_B)
				oth_q <= nrm;
			else
				acc_q <= nrm;
		end
	end

endmodule

// ===== sv/pdf_div.sv =====
// ---------------------------------------------------------------------------
// Peer delay filter divider
// Two restoring division lanes sharing one divisor, one bit per cycle.
// ---------------------------------------------------------------------------
module pdf_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [30:0] divisor,
	input  logic [31:0] dvd0,
	input  logic [31:0] dvd1,
	output logic [31:0] quo0,
	output logic [31:0] quo1,
	output logic [31:0] rem0,
	output logic        done
);

	localparam int CNT_W = $clog2(pdf_pkg::DIV_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [31:0]      dv_q;
	logic [31:0]      a0_q, a1_q, r0_q, r1_q;
	logic [31:0]      tr0, tr1;
	logic             ge0, ge1;
	logic             done_q;

	assign tr0 = {r0_q[30:0], a0_q[31]};
	assign tr1 = {r1_q[30:0], a1_q[31]};
	assign ge0 = (tr0 >= dv_q);
	assign ge1 = (tr1 >= dv_q);

	assign quo0 = a0_q;
	assign quo1 = a1_q;
	assign rem0 = r0_q;
	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (start)
				cnt_q <= CNT_W'(pdf_pkg::DIV_W);
			else if (cnt_q != '0)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dv_q <= {1'b0, divisor};
			a0_q <= dvd0;
			a1_q <= dvd1;
			r0_q <= '0;
			r1_q <= '0;
		end else if (cnt_q != '0) begin
			r0_q <= ge0 ? tr0 - dv_q : tr0;
			r1_q <= ge1 ? tr1 - dv_q : tr1;
			a0_q <= {a0_q[30:0], ge0};
			a1_q <= {a1_q[30:0], ge1};
		end
	end

endmodule

// ===== sv/pdf_back.sv =====
// ---------------------------------------------------------------------------
// Peer delay filter back end
// Runs the adaptive smoothing filter, or clears it on a delay of a second or more, and holds the result for the reader.
// ---------------------------------------------------------------------------
module pdf_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [pdf_pkg::STIFF_W-1:0] stiffness,
	input  logic                       q_empty,
	output logic                       q_pop,
	input  pdf_pkg::pdf_pair_t         q_data,
	output logic                       empty,
	input  logic                       pop,
	output logic [31:0]                delay_sec,
	output logic [30:0]                delay_ns,
	output logic                       filter_cleared
);

	pdf_pkg::back_state_t state_q, state_d;
	pdf_pkg::pdf_pair_t   d_q;
	logic                 clear_q;
	logic [4:0]           s_q;
	logic [30:0]          step_q, lim;
	logic signed [31:0]   y_q, prev_q, ynew_q;
	logic signed [31:0]   n_sum, dns_ext;
	logic [31:0]          mag_y, mag_n, quo0, quo1, rem0, m1;
	logic signed [33:0]   term1, term2, sum;
	logic                 div_start, div_done, shrink, res_load;
	logic                 res_valid_q;
	logic [31:0]          res_sec_q;
	logic [30:0]          res_ns_q;
	logic                 res_clr_q;

	assign mag_y   = y_q[31] ? (~y_q + 32'd1) : y_q;
	assign dns_ext = {d_q.ns[30], d_q.ns};
	// Both halves truncate towards zero before they are added.
	assign n_sum   = (($signed(dns_ext) >>> 1) + $signed({31'd0, dns_ext[31] & dns_ext[0]}))
		+ ((prev_q >>> 1) + $signed({31'd0, prev_q[31] & prev_q[0]}));
	assign mag_n   = n_sum[31] ? (~n_sum + 32'd1) : n_sum;
	assign shrink  = (s_q != 5'd0) && ((mag_y >> (5'd31 - s_q)) != 32'd0);
	assign lim     = 31'd1 << s_q;

	// Truncated (a-1)*y/a is |y| less the rounded-up quotient, with y's sign.
	assign m1    = mag_y - quo0 - {31'd0, rem0 != 32'd0};
	assign term1 = y_q[31] ? -$signed({2'b00, m1}) : $signed({2'b00, m1});
	assign term2 = n_sum[31] ? -$signed({2'b00, quo1}) : $signed({2'b00, quo1});
	assign sum   = term1 + term2;

	pdf_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.divisor (step_q),
		.dvd0    (mag_y),
		.dvd1    (mag_n),
		.quo0    (quo0),
		.quo1    (quo1),
		.rem0    (rem0),
		.done    (div_done)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			pdf_pkg::BK_IDLE: begin
				if (!q_empty)
					state_d = (q_data.sec != 32'd0) ? pdf_pkg::BK_OUT : pdf_pkg::BK_SEARCH;
			end
			pdf_pkg::BK_SEARCH: if (!shrink) state_d = pdf_pkg::BK_STEP;
			pdf_pkg::BK_STEP:   state_d = pdf_pkg::BK_DIV;
			pdf_pkg::BK_DIV:    state_d = pdf_pkg::BK_WAIT;
			pdf_pkg::BK_WAIT:   if (div_done) state_d = pdf_pkg::BK_SUM;
			pdf_pkg::BK_SUM:    state_d = pdf_pkg::BK_OUT;
			pdf_pkg::BK_OUT:    if (!res_valid_q) state_d = pdf_pkg::BK_IDLE;
			default:            state_d = pdf_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop     = (state_q == pdf_pkg::BK_IDLE) && !q_empty;
		div_start = (state_q == pdf_pkg::BK_DIV);
		res_load  = (state_q == pdf_pkg::BK_OUT) && !res_valid_q;
	end

	assign empty          = !res_valid_q;
	assign delay_sec      = res_sec_q;
	assign delay_ns       = res_ns_q;
	assign filter_cleared = res_clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pdf_pkg::BK_IDLE;
			step_q      <= '0;
			y_q         <= '0;
			prev_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == pdf_pkg::BK_STEP) begin
				if (step_q == 31'd0)
					step_q <= 31'd1;
				else if (step_q < lim)
					step_q <= step_q + 31'd1;
				else if (step_q > lim)
					step_q <= lim;
			end
			if (res_load) begin
				if (clear_q) begin
					step_q <= '0;
					prev_q <= '0;
				end else begin
					y_q    <= ynew_q;
					prev_q <= dns_ext;
				end
			end
			if (res_load)
				res_valid_q <= 1'b1;
			else if (pop)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			d_q     <= q_data;
			clear_q <= (q_data.sec != 32'd0);
			s_q     <= (stiffness > pdf_pkg::STIFF_MAX) ? pdf_pkg::STIFF_MAX : stiffness;
		end else if (state_q == pdf_pkg::BK_SEARCH && shrink) begin
			s_q <= s_q - 5'd1;
		end
		if (state_q == pdf_pkg::BK_SUM)
			ynew_q <= sum[31:0];
		if (res_load) begin
			res_clr_q <= clear_q;
			res_sec_q <= clear_q ? d_q.sec : 32'd0;
			res_ns_q  <= clear_q ? d_q.ns : ynew_q[30:0];
		end
	end

endmodule

// ===== sv/peer_delay_iir_filter.sv =====
// ---------------------------------------------------------------------------
// Peer delay IIR filter
// Peer delay from one exchange, smoothed by an adaptive recursive filter.
// ---------------------------------------------------------------------------
// Each request is one peer-delay exchange. The front end works the delay
// arithmetic of a two-step exchange in five pair operations, or of a one-step
// exchange in three, each a raw step followed by a normalising step.
// It then hands the halved delay to a two-entry queue, so a new exchange can
// be taken while the back end is still filtering. The back end first lowers
// the stiffness step by step while the overflow guard demands it, then runs
// the bit-serial divider on two lanes at once and sums the terms. A delay of
// a second or more skips the filter. Held exchanges are taken at once and
// give no result.
// The stiffness register may be written at any time the block is idle.
module peer_delay_iir_filter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data,
	input  logic        push,
	output logic        full,
	input  logic        two_step,
	input  logic        leap_hold,
	input  logic [31:0] req_send_sec,
	input  logic [29:0] req_send_ns,
	input  logic [31:0] req_recv_sec,
	input  logic [29:0] req_recv_ns,
	input  logic [31:0] resp_send_sec,
	input  logic [29:0] resp_send_ns,
	input  logic [31:0] resp_recv_sec,
	input  logic [29:0] resp_recv_ns,
	input  logic [31:0] corr_sec,
	input  logic [30:0] corr_ns,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] delay_sec,
	output logic [30:0] delay_ns,
	output logic        filter_cleared
);

	logic [pdf_pkg::STIFF_W-1:0] stiff_q;
	logic                        fq_push, fq_full, fq_pop, fq_empty;
	pdf_pkg::pdf_pair_t          fq_wdata, fq_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			stiff_q <= pdf_pkg::STIFF_RESET;
		else if (cfg_valid && cfg_ready)
			stiff_q <= cfg_data;
	end

	pdf_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.two_step      (two_step),
		.leap_hold     (leap_hold),
		.req_send_sec  (req_send_sec),
		.req_send_ns   (req_send_ns),
		.req_recv_sec  (req_recv_sec),
		.req_recv_ns   (req_recv_ns),
		.resp_send_sec (resp_send_sec),
		.resp_send_ns  (resp_send_ns),
		.resp_recv_sec (resp_recv_sec),
		.resp_recv_ns  (resp_recv_ns),
		.corr_sec      (corr_sec),
		.corr_ns       (corr_ns),
		.q_push        (fq_push),
		.q_full        (fq_full),
		.q_data        (fq_wdata)
	);

	pdf_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fq_push),
		.full   (fq_full),
		.wdata  (fq_wdata),
		.pop    (fq_pop),
		.empty  (fq_empty),
		.rdata  (fq_rdata)
	);

	pdf_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.stiffness      (stiff_q),
		.q_empty        (fq_empty),
		.q_pop          (fq_pop),
		.q_data         (fq_rdata),
		.empty          (empty),
		.pop            (pop),
		.delay_sec      (delay_sec),
		.delay_ns       (delay_ns),
		.filter_cleared (filter_cleared)
	);

	// A filtered result always has zero seconds.
	a_filtered_zero_sec: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !filter_cleared) |-> (delay_sec == 32'd0))
		else $error("filtered result carries nonzero seconds");

	// An exchange that is worked on keeps the front busy in the next cycle.
	a_front_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && !leap_hold) |=> full)
		else $error("front end free right after taking an exchange");

	// A held exchange leaves the front free.
	a_hold_free: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && leap_hold) |=> !full)
		else $error("held exchange occupied the front end");

endmodule
